// ----- design/nvtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VTG parser package
// Shared constants, character codes, types and lookup functions.
// ----------------------------------------------------------------------------
package nvtg_pkg;

   localparam int MAX_LINE = 100;
   localparam logic [6:0] LINE_LIMIT = 7'(MAX_LINE - 2);
   localparam logic [6:0] LEN_SAT = 7'd127;
   localparam logic [6:0] XOR_START = 7'd6;
   localparam logic [19:0] SAT_MAX = 20'd999999;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
   localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_A     = 8'h41;

   localparam logic [3:0] FLD_HEAD   = 4'd0;
   localparam logic [3:0] FLD_COURSE = 4'd1;
   localparam logic [3:0] FLD_T      = 4'd2;
   localparam logic [3:0] FLD_M      = 4'd3;
   localparam logic [3:0] FLD_SPEED  = 4'd4;
   localparam logic [3:0] FLD_N      = 4'd5;
   localparam logic [3:0] FLD_ANY    = 4'd6;
   localparam logic [3:0] FLD_K      = 4'd7;
   localparam logic [3:0] FLD_CHECK  = 4'd8;
   localparam logic [3:0] FLD_SAT    = 4'd15;

   localparam logic [2:0] HEAD_LEN = 3'd6;
   localparam logic [2:0] CIF_SAT  = 3'd7;
   localparam logic [1:0] FRAC_MAX = 2'd3;

   // classified byte handed from the front end to the parser
   typedef struct packed {
      logic [7:0] data;
      logic       is_nl;
      logic       is_comma;
      logic       is_digit;
      logic       is_point;
      logic       hex_ok;
      logic [3:0] nibble;
   } byte_class_type;

   typedef struct packed {
      logic        ok;
      logic [19:0] course;
      logic [19:0] speed;
   } rsp_item_type;

   typedef struct packed {
      logic [19:0] acc;
      logic        point;
      logic [1:0]  frac;
      logic        err;
   } dec_step_type;

   function automatic byte_class_type classify(input logic [7:0] c);
      byte_class_type r;
      r.data     = c;
      r.is_nl    = (c == CH_NL);
      r.is_comma = (c == CH_COMMA);
      r.is_point = (c == CH_POINT);
      r.is_digit = (c >= 8'h30) && (c <= 8'h39);
      r.hex_ok   = 1'b0;
      r.nibble   = 4'd0;
      if (r.is_digit) begin
         r.hex_ok = 1'b1;
         r.nibble = 4'(c - 8'h30);
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r.hex_ok = 1'b1;
         r.nibble = 4'(c - 8'h37);
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r.hex_ok = 1'b1;
         r.nibble = 4'(c - 8'h57);
      end
      return r;
   endfunction

   function automatic logic [7:0] head_char(input logic [2:0] pos);
      unique case (pos)
         3'd0: head_char = 8'h24;  // $
         3'd1: head_char = 8'h47;  // G
         3'd2: head_char = 8'h50;  // P
         3'd3: head_char = 8'h56;  // V
         3'd4: head_char = 8'h54;  // T
         3'd5: head_char = 8'h47;  // G
         default: head_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] single_char(input logic [3:0] fld);
      unique case (fld)
         FLD_T:   single_char = 8'h54;
         FLD_M:   single_char = 8'h4D;
         FLD_N:   single_char = 8'h4E;
         FLD_K:   single_char = 8'h4B;
         default: single_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [6:0] frac_weight(input logic [1:0] idx);
      unique case (idx)
         2'd0:    frac_weight = 7'd100;
         2'd1:    frac_weight = 7'd10;
         2'd2:    frac_weight = 7'd1;
         default: frac_weight = 7'd0;
      endcase
   endfunction

endpackage

// ----- design/nvtg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VTG parser front end
// Accepts bytes, drops NUL, classifies and queues them for the parser.
// ----------------------------------------------------------------------------
module nvtg_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              req_rx_byte,
   output logic                    item_valid,
   output nvtg_pkg::byte_class_type item,
   input  logic                    item_take
);
   import nvtg_pkg::*;

   byte_class_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    wr_ff, wr_in;
   logic [Q_PTR_W-1:0]    rd_ff, rd_in;
   logic [Q_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                  wr_en;
   logic                  rd_en;

   assign full       = (cnt_ff == Q_FULL);
   assign item_valid = (cnt_ff != '0);
   assign item       = entry_ff[rd_ff];

   // store only non-NUL bytes
   assign wr_en = push && !full && (req_rx_byte != CH_NUL);
   assign rd_en = item_take && item_valid;

   always_comb begin
      wr_in  = wr_en ? Q_PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = rd_en ? Q_PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = Q_CNT_W'(cnt_ff + 1'b1);
      end else if (!wr_en && rd_en) begin
         cnt_in = Q_CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ff] <= classify(req_rx_byte);
      end
   end

endmodule

// ----- design/nvtg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VTG parser back end
// Tokenizes classified bytes, checks fields and checksum, queues results.
// ----------------------------------------------------------------------------
module nvtg_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  nvtg_pkg::byte_class_type item,
   output logic                     item_take,
   output logic                     empty,
   input  logic                     pop,
   output logic                     rsp_sentence_ok,
   output logic [19:0]              rsp_course_milli,
   output logic [19:0]              rsp_speed_milli
);
   import nvtg_pkg::*;

   logic [6:0]  len_ff, len_in;
   logic [3:0]  fld_ff, fld_in;
   logic        fne_ff, fne_in;
   logic [2:0]  cif_ff, cif_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  recent_ff [5];
   logic [7:0]  recent_in [5];
   logic        err_ff, err_in;
   logic [19:0] course_ff, course_in;
   logic [19:0] speed_ff, speed_in;
   logic        ps_ff, ps_in;
   logic [1:0]  fd_ff, fd_in;
   logic [7:0]  chk_ff, chk_in;

   rsp_item_type          rq_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    rq_wr_ff, rq_wr_in;
   logic [Q_PTR_W-1:0]    rq_rd_ff, rq_rd_in;
   logic [Q_CNT_W-1:0]    rq_cnt_ff, rq_cnt_in;
   logic                  rsp_push;
   rsp_item_type          rsp_new;
   logic                  rsp_pop;

   function automatic dec_step_type dec_step(input logic [19:0] acc,
                                             input byte_class_type c,
                                             input logic point,
                                             input logic [1:0] frac);
      dec_step_type r;
      logic [24:0]  sum;
      r.acc   = acc;
      r.point = point;
      r.frac  = frac;
      r.err   = 1'b0;
      sum     = '0;
      if (c.is_digit) begin
         if (!point) begin
            sum   = 25'(acc) * 25'd10 + 25'(c.nibble) * 25'd1000;
            r.acc = (sum > 25'(SAT_MAX)) ? SAT_MAX : sum[19:0];
         end else if (frac < FRAC_MAX) begin
            sum    = 25'(acc) + 25'(c.nibble) * 25'(frac_weight(frac));
            r.acc  = (sum > 25'(SAT_MAX)) ? SAT_MAX : sum[19:0];
            r.frac = 2'(frac + 1'b1);
         end
      end else if (c.is_point && !point) begin
         r.point = 1'b1;
      end else begin
         r.err = 1'b1;
      end
      return r;
   endfunction

   assign item_take = item_valid && (rq_cnt_ff != Q_FULL);

   always_comb begin
      logic [2:0]   pos;
      logic         ok;
      dec_step_type ds;

      len_in    = len_ff;
      fld_in    = fld_ff;
      fne_in    = fne_ff;
      cif_in    = cif_ff;
      xor_in    = xor_ff;
      recent_in = recent_ff;
      err_in    = err_ff;
      course_in = course_ff;
      speed_in  = speed_ff;
      ps_in     = ps_ff;
      fd_in     = fd_ff;
      chk_in    = chk_ff;
      rsp_push  = 1'b0;
      rsp_new   = '0;
      pos       = cif_ff;
      ok        = 1'b0;
      ds        = '0;

      if (item_take) begin
         if (len_ff >= XOR_START) begin
            xor_in = xor_ff ^ recent_ff[4];
         end
         recent_in[0] = item.data;
         for (int i = 1; i < 5; i++) begin
            recent_in[i] = recent_ff[i-1];
         end

         if (!item.is_nl) begin
            if (len_ff >= LINE_LIMIT) begin
               err_in = 1'b1;
            end
            if (len_ff < LEN_SAT) begin
               len_in = 7'(len_ff + 1'b1);
            end
         end

         if (item.is_comma) begin
            // close the open token, if any
            if (fne_ff) begin
               if ((fld_ff == FLD_HEAD) && (cif_ff != HEAD_LEN)) begin
                  err_in = 1'b1;
               end
               if (((fld_ff == FLD_COURSE) || (fld_ff == FLD_SPEED)) &&
                   (cif_ff <= {2'b00, ps_ff})) begin
                  err_in = 1'b1;
               end
               if (fld_ff >= FLD_CHECK) begin
                  err_in = 1'b1;
               end
               fne_in = 1'b0;
               if (fld_ff < FLD_SAT) begin
                  fld_in = 4'(fld_ff + 1'b1);
               end
            end
         end else begin
            // open a token on its first byte
            if (!fne_ff) begin
               pos   = '0;
               ps_in = 1'b0;
               fd_in = '0;
            end
            fne_in = 1'b1;
            unique case (fld_ff)
               FLD_HEAD: begin
                  if ((pos >= HEAD_LEN) || (item.data != head_char(pos))) begin
                     err_in = 1'b1;
                  end
               end
               FLD_COURSE: begin
                  ds        = dec_step(course_ff, item, ps_in, fd_in);
                  course_in = ds.acc;
                  ps_in     = ds.point;
                  fd_in     = ds.frac;
                  if (ds.err) begin
                     err_in = 1'b1;
                  end
               end
               FLD_SPEED: begin
                  ds       = dec_step(speed_ff, item, ps_in, fd_in);
                  speed_in = ds.acc;
                  ps_in    = ds.point;
                  fd_in    = ds.frac;
                  if (ds.err) begin
                     err_in = 1'b1;
                  end
               end
               FLD_T, FLD_M, FLD_N, FLD_K: begin
                  if ((pos != '0) || (item.data != single_char(fld_ff))) begin
                     err_in = 1'b1;
                  end
               end
               FLD_ANY: begin
               end
               FLD_CHECK: begin
                  if (pos == 3'd0) begin
                     if (item.data != CH_A) begin
                        err_in = 1'b1;
                     end
                  end else if (pos == 3'd1) begin
                     if (item.data != CH_STAR) begin
                        err_in = 1'b1;
                     end
                  end else if (pos <= 3'd3) begin
                     if (!item.hex_ok) begin
                        err_in = 1'b1;
                     end else begin
                        chk_in = {chk_ff[3:0], item.nibble};
                     end
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
            cif_in = (pos < CIF_SAT) ? 3'(pos + 1'b1) : CIF_SAT;
         end

         if (item.is_nl) begin
            ok = !err_in && fne_in && (fld_in == FLD_CHECK) && (chk_in == xor_in);
            rsp_push       = 1'b1;
            rsp_new.ok     = ok;
            rsp_new.course = ok ? course_in : '0;
            rsp_new.speed  = ok ? speed_in : '0;
            // start the next line from scratch
            len_in    = '0;
            fld_in    = '0;
            fne_in    = 1'b0;
            cif_in    = '0;
            xor_in    = '0;
            for (int i = 0; i < 5; i++) begin
               recent_in[i] = '0;
            end
            err_in    = 1'b0;
            course_in = '0;
            speed_in  = '0;
            ps_in     = 1'b0;
            fd_in     = '0;
            chk_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         fld_ff    <= '0;
         fne_ff    <= 1'b0;
         cif_ff    <= '0;
         xor_ff    <= '0;
         for (int i = 0; i < 5; i++) begin
            recent_ff[i] <= '0;
         end
         err_ff    <= 1'b0;
         course_ff <= '0;
         speed_ff  <= '0;
         ps_ff     <= 1'b0;
         fd_ff     <= '0;
         chk_ff    <= '0;
      end else begin
         len_ff    <= len_in;
         fld_ff    <= fld_in;
         fne_ff    <= fne_in;
         cif_ff    <= cif_in;
         xor_ff    <= xor_in;
         recent_ff <= recent_in;
         err_ff    <= err_in;
         course_ff <= course_in;
         speed_ff  <= speed_in;
         ps_ff     <= ps_in;
         fd_ff     <= fd_in;
         chk_ff    <= chk_in;
      end
   end

   // result queue
   assign empty            = (rq_cnt_ff == '0);
   assign rsp_pop          = pop && !empty;
   assign rsp_sentence_ok  = rq_ff[rq_rd_ff].ok;
   assign rsp_course_milli = rq_ff[rq_rd_ff].course;
   assign rsp_speed_milli  = rq_ff[rq_rd_ff].speed;

   always_comb begin
      rq_wr_in  = rsp_push ? Q_PTR_W'(rq_wr_ff + 1'b1) : rq_wr_ff;
      rq_rd_in  = rsp_pop ? Q_PTR_W'(rq_rd_ff + 1'b1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rsp_push && !rsp_pop) begin
         rq_cnt_in = Q_CNT_W'(rq_cnt_ff + 1'b1);
      end else if (!rsp_push && rsp_pop) begin
         rq_cnt_in = Q_CNT_W'(rq_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wr_ff] <= rsp_new;
      end
   end

endmodule

// ----- design/nmea_vtg_sentence_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA VTG sentence parser
// Byte-stream checker for VTG sentences with course and speed extraction.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received serial bytes on req_rx_byte with push; a byte is taken on
//   a clock edge with push high and full low. NUL bytes are taken and
//   dropped. Each newline byte yields exactly one result on the rsp_ ports,
//   readable while empty is low and removed on an edge with pop high.
//   A result flags a valid, checksummed VTG sentence with fix and carries
//   course and speed in thousandths (zero when the sentence is rejected).
// Timing:
//   One byte per cycle sustained while the result queue has room. The
//   front queue registers the byte, the parser then takes it from the
//   front queue, and a result is written into the result queue on the
//   edge that takes its newline.
// Reset and stall:
//   Synchronous reset empties both queues and clears the line state.
//   When the receiver does not pop, up to two results wait in the result
//   queue; the parser then holds and the front queue fills until full rises.
// ----------------------------------------------------------------------------
module nmea_vtg_sentence_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_sentence_ok,
   output logic [19:0] rsp_course_milli,
   output logic [19:0] rsp_speed_milli
);
   import nvtg_pkg::*;

   // classified byte stream between front end and parser
   logic           item_valid;
   byte_class_type item;
   logic           item_take;

   // accept and classify incoming bytes
   nvtg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take)
   );

   // tokenize, check and queue one result per line
   nvtg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_sentence_ok  (rsp_sentence_ok),
      .rsp_course_milli (rsp_course_milli),
      .rsp_speed_milli  (rsp_speed_milli)
   );

endmodule
